### design/vobf_pkg.sv
`default_nettype none

package vobf_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_VOLUME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_VOLUME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_VOLUME_DEPTH  = 2'd2;
    localparam logic [1:0] REG_THRESHOLD     = 2'd3;

    // Output queue geometry
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = 2;
    localparam int OUTQ_CW    = 3;

    // floor(255 * n / 27) for n = 0..27 occupied voxels
    localparam logic [7:0] DENSITY_LUT [0:27] = '{
        8'd0,   8'd9,   8'd18,  8'd28,  8'd37,  8'd47,  8'd56,
        8'd66,  8'd75,  8'd85,  8'd94,  8'd103, 8'd113, 8'd122,
        8'd132, 8'd141, 8'd151, 8'd160, 8'd170, 8'd179, 8'd188,
        8'd198, 8'd207, 8'd217, 8'd226, 8'd236, 8'd245, 8'd255
    };

    // One filtered voxel, center_x in the lowest bits
    typedef struct packed {
        logic [7:0] density_byte;
        logic [5:0] center_z;
        logic [5:0] center_y;
        logic [5:0] center_x;
    } result_t;

    // Window pipeline stages that hold an item which will yield a result
    typedef struct packed {
        logic p1_emit;
        logic p2_emit;
    } pipe_status_t;

endpackage

`default_nettype wire

### design/vobf_ram.sv
`default_nettype none

module vobf_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### design/vobf_window.sv
`default_nettype none

module vobf_window #(
    parameter int MAX_DIM = 64,
    localparam int CW = $clog2(MAX_DIM)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    input  wire logic                  in_occ,
    input  wire logic                  in_emit,
    input  wire logic [CW-1:0]         in_x,
    input  wire logic [CW-1:0]         in_y,
    input  wire logic [CW-1:0]         in_z,
    output logic                       res_valid,
    output vobf_pkg::result_t          res,
    output vobf_pkg::pipe_status_t     status
);

    // Stage 1 registers (memory read in flight)
    logic          p1_valid_reg;
    logic          p1_occ_reg;
    logic          p1_emit_reg;
    logic [CW-1:0] p1_x_reg;
    logic [CW-1:0] p1_y_reg;
    logic [CW-1:0] p1_z_reg;

    // Stage 2 registers (slice counts ready)
    logic          p2_valid_reg;
    logic [CW-1:0] p2_x_reg;
    logic [CW-1:0] p2_y_reg;
    logic [CW-1:0] p2_z_reg;
    logic [3:0]    cnt_reg [0:2];

    // Memory ports
    logic [1:0]    col_rd;
    logic [5:0]    row_rd;
    logic [2:0]    col3;
    logic [8:0]    slice;
    logic [3:0]    slice_cnt;
    logic [4:0]    total;
    logic [CW+5:0] cx_ext;
    logic [CW+5:0] cy_ext;
    logic [CW+5:0] cz_ext;

    // Column history per (x, y): bit 0 = previous plane, bit 1 = the one before
    vobf_ram #(
        .WIDTH (2),
        .DEPTH (2 ** (2 * CW))
    ) u_col_ram (
        .aclk    (aclk),
        .wr_en   (p1_valid_reg),
        .wr_addr ({p1_y_reg, p1_x_reg}),
        .wr_data ({col_rd[0], p1_occ_reg}),
        .rd_en   (in_valid),
        .rd_addr ({in_y, in_x}),
        .rd_data (col_rd)
    );

    // Row history per x: low 3 bits = column of previous row, high 3 = row before
    vobf_ram #(
        .WIDTH (6),
        .DEPTH (2 ** CW)
    ) u_row_ram (
        .aclk    (aclk),
        .wr_en   (p1_valid_reg),
        .wr_addr (p1_x_reg),
        .wr_data ({row_rd[2:0], col3}),
        .rd_en   (in_valid),
        .rd_addr (in_x),
        .rd_data (row_rd)
    );

    // Assemble the 3x3 slice at this x and count its occupied voxels
    assign col3  = {col_rd[1], col_rd[0], p1_occ_reg};
    assign slice = {row_rd, col3};

    always_comb begin
        slice_cnt = '0;
        for (int i = 0; i < 9; i++) begin
            slice_cnt = slice_cnt + 4'(slice[i]);
        end
    end

    // Capture accepted transaction into stage 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= in_valid;
        end
        if (in_valid) begin
            p1_occ_reg  <= in_occ;
            p1_emit_reg <= in_emit;
            p1_x_reg    <= in_x;
            p1_y_reg    <= in_y;
            p1_z_reg    <= in_z;
        end
    end

    // Advance slice counts along the row and hand emitting items to stage 2
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else begin
            p2_valid_reg <= p1_valid_reg && p1_emit_reg;
        end
        if (p1_valid_reg) begin
            cnt_reg[0] <= slice_cnt;
            cnt_reg[1] <= cnt_reg[0];
            cnt_reg[2] <= cnt_reg[1];
            p2_x_reg   <= p1_x_reg;
            p2_y_reg   <= p1_y_reg;
            p2_z_reg   <= p1_z_reg;
        end
    end

    // Sum the three slices and map to a density byte
    assign total  = 5'(cnt_reg[0]) + 5'(cnt_reg[1]) + 5'(cnt_reg[2]);
    assign cx_ext = {6'd0, p2_x_reg - CW'(1)};
    assign cy_ext = {6'd0, p2_y_reg - CW'(1)};
    assign cz_ext = {6'd0, p2_z_reg - CW'(1)};

    always_comb begin
        res.center_x     = cx_ext[5:0];
        res.center_y     = cy_ext[5:0];
        res.center_z     = cz_ext[5:0];
        res.density_byte = vobf_pkg::DENSITY_LUT[total];
    end

    assign res_valid      = p2_valid_reg;
    assign status.p1_emit = p1_valid_reg && p1_emit_reg;
    assign status.p2_emit = p2_valid_reg;

    // An emitting item reaches the result stage on the next cycle
    a_emit_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && p1_emit_reg) |=> res_valid)
        else $error("emitting item did not reach result stage");

endmodule

`default_nettype wire

### design/vobf_outq.sv
`default_nettype none

module vobf_outq (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        push,
    input  wire vobf_pkg::result_t           push_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output vobf_pkg::result_t                out_data,
    output logic [vobf_pkg::OUTQ_CW-1:0]     count
);

    vobf_pkg::result_t                entry_reg [0:vobf_pkg::OUTQ_DEPTH-1];
    logic [vobf_pkg::OUTQ_AW-1:0]     wr_ptr_reg;
    logic [vobf_pkg::OUTQ_AW-1:0]     rd_ptr_reg;
    logic [vobf_pkg::OUTQ_CW-1:0]     count_reg;
    logic                             pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    // Store incoming result
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg < vobf_pkg::OUTQ_CW'(vobf_pkg::OUTQ_DEPTH)) || pop)
        else $error("output queue overflow");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= vobf_pkg::OUTQ_CW'(vobf_pkg::OUTQ_DEPTH))
        else $error("output queue count out of range");

endmodule

`default_nettype wire

### design/voxel_occupancy_box_filter.sv
// Voxel occupancy 3x3x3 box filter.
// Input stream (s_*): one voxel per transaction in raster order, x fastest,
// then y, then z; s_tdata[15:0] is the unsigned Q4.12 sample.
// Output stream (m_*): one transaction per interior voxel, issued when the
// far corner of its window arrives; m_tdata carries the center coordinates
// and floor(255 * occupied / 27).
// Configuration: cfg_we / cfg_addr / cfg_wdata write volume width, height,
// depth and the occupancy threshold; a dimension write restarts the volume.
// Throughput: one voxel per cycle while s_tready is high. From input
// transaction to m_tvalid: occupancy history memory read, slice count,
// window sum and density table into a 4-entry output queue.
// s_tready follows the queue's free space counted against results still in
// the pipeline, so a stalled receiver fills the queue and then holds s_tready
// low; nothing is dropped.
// Reset clears the position to the volume origin, the dimensions to 64 and
// the threshold to 410. The history memories need no clearing pass: every
// window reads only entries written earlier in the same volume.
`default_nettype none

module voxel_occupancy_box_filter #(
    parameter int MAX_DIM = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // voxel_value[15:0]
    input  wire logic [15:0] s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // center_x[5:0], center_y[11:6], center_z[17:12], density_byte[25:18]
    output logic [31:0]      m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = (CW + 1 > 7) ? CW + 1 : 7;

    logic [6:0]    width_reg;
    logic [6:0]    height_reg;
    logic [6:0]    depth_reg;
    logic [15:0]   thresh_reg;
    logic [CW-1:0] pos_x_reg;
    logic [CW-1:0] pos_y_reg;
    logic [CW-1:0] pos_z_reg;
    logic [CW-1:0] pos_x_next;
    logic [CW-1:0] pos_y_next;
    logic [CW-1:0] pos_z_next;

    logic [DW-1:0] w_eff;
    logic [DW-1:0] h_eff;
    logic [DW-1:0] d_eff;
    logic [DW-1:0] x_inc;
    logic [DW-1:0] y_inc;
    logic [DW-1:0] z_inc;

    logic                              accept;
    logic                              dim_write;
    logic                              occ;
    logic                              emit;
    logic                              res_valid;
    vobf_pkg::result_t                 res;
    vobf_pkg::result_t                 q_data;
    vobf_pkg::pipe_status_t            status;
    logic [vobf_pkg::OUTQ_CW-1:0]      q_count;
    logic [vobf_pkg::OUTQ_CW-1:0]      committed;

    function automatic logic [DW-1:0] clamp_dim(input logic [6:0] v);
        logic [DW-1:0] e;
        e = DW'(v);
        if (e < DW'(3)) begin
            return DW'(3);
        end else if (e > DW'(MAX_DIM)) begin
            return DW'(MAX_DIM);
        end
        return e;
    endfunction

    assign w_eff = clamp_dim(width_reg);
    assign h_eff = clamp_dim(height_reg);
    assign d_eff = clamp_dim(depth_reg);

    // Admit a voxel only while its result is sure to find queue space
    assign committed = q_count + vobf_pkg::OUTQ_CW'(status.p1_emit)
                     + vobf_pkg::OUTQ_CW'(status.p2_emit);
    assign s_tready  = committed < vobf_pkg::OUTQ_CW'(vobf_pkg::OUTQ_DEPTH);
    assign accept    = s_tvalid && s_tready;

    assign occ  = s_tdata > thresh_reg;
    assign emit = (pos_x_reg >= CW'(2)) && (pos_y_reg >= CW'(2))
               && (pos_z_reg >= CW'(2));

    assign dim_write = cfg_we && (cfg_addr == vobf_pkg::REG_VOLUME_WIDTH
                               || cfg_addr == vobf_pkg::REG_VOLUME_HEIGHT
                               || cfg_addr == vobf_pkg::REG_VOLUME_DEPTH);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 7'd64;
            height_reg <= 7'd64;
            depth_reg  <= 7'd64;
            thresh_reg <= 16'd410;
        end else if (cfg_we) begin
            case (cfg_addr)
                vobf_pkg::REG_VOLUME_WIDTH:  width_reg  <= cfg_wdata[6:0];
                vobf_pkg::REG_VOLUME_HEIGHT: height_reg <= cfg_wdata[6:0];
                vobf_pkg::REG_VOLUME_DEPTH:  depth_reg  <= cfg_wdata[6:0];
                vobf_pkg::REG_THRESHOLD:     thresh_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Raster position advance with row, plane and volume wrap
    always_comb begin
        x_inc      = DW'(pos_x_reg) + DW'(1);
        y_inc      = DW'(pos_y_reg) + DW'(1);
        z_inc      = DW'(pos_z_reg) + DW'(1);
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        pos_z_next = pos_z_reg;
        if (x_inc >= w_eff) begin
            pos_x_next = '0;
            if (y_inc >= h_eff) begin
                pos_y_next = '0;
                if (z_inc >= d_eff) begin
                    pos_z_next = '0;
                end else begin
                    pos_z_next = z_inc[CW-1:0];
                end
            end else begin
                pos_y_next = y_inc[CW-1:0];
            end
        end else begin
            pos_x_next = x_inc[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || dim_write) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
        end else if (accept) begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
        end
    end

    vobf_window #(
        .MAX_DIM (MAX_DIM)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_occ    (occ),
        .in_emit   (emit),
        .in_x      (pos_x_reg),
        .in_y      (pos_y_reg),
        .in_z      (pos_z_reg),
        .res_valid (res_valid),
        .res       (res),
        .status    (status)
    );

    vobf_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (q_data),
        .count     (q_count)
    );

    assign m_tdata = {6'd0, q_data};

    a_dim_write_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        dim_write |=> (pos_x_reg == '0 && pos_y_reg == '0 && pos_z_reg == '0))
        else $error("dimension write did not restart the volume");

    a_pos_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        DW'(pos_x_reg) < w_eff)
        else $error("x position beyond row width");

endmodule

`default_nettype wire
